@@ rtl/scfr_pkg.sv @@
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the serial command frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

   localparam int PAYLOAD_DEPTH_DEF = 64;
   localparam int BYTE_W            = 8;

   localparam logic [BYTE_W-1:0] SYNC_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] SYNC_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] SYNC_LT     = 8'h3C;

   typedef struct packed {
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] size;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

endpackage

@@ rtl/scfr_front.sv @@
// ----------------------------------------------------------------------------
// scfr_front
// Frame parser: tracks the header, stores payload bytes into the free bank
// of the payload buffer and queues a descriptor when the checksum matches.
// ----------------------------------------------------------------------------
module scfr_front #(
   parameter int PAYLOAD_DEPTH = scfr_pkg::PAYLOAD_DEPTH_DEF,
   parameter int SZ_W          = $clog2(PAYLOAD_DEPTH + 1),
   parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      q_full,
   output logic                      q_push,
   output scfr_pkg::desc_type        q_desc,
   output scfr_pkg::mem_wr_type      mem_wr,
   output logic [AW:0]               mem_wr_addr
);
   import scfr_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_DOLLAR = 3'd1;
   localparam logic [2:0] PH_M      = 3'd2;
   localparam logic [2:0] PH_ARROW  = 3'd3;
   localparam logic [2:0] PH_SIZE   = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;

   logic [2:0]        phase_ff, phase_in;
   logic [SZ_W-1:0]   size_ff, size_in;
   logic [SZ_W-1:0]   fill_ff, fill_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              bank_ff, bank_in;
   logic              accept;
   logic              body_store;

   assign req_tready = (phase_ff != PH_BODY) || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign body_store = (phase_ff == PH_BODY) && (fill_ff < size_ff);

   assign mem_wr.en    = accept && body_store;
   assign mem_wr.data  = req_tdata;
   assign mem_wr_addr  = {bank_ff, fill_ff[AW-1:0]};

   assign q_push      = accept && (phase_ff == PH_BODY) && !body_store &&
                        (xor_ff == req_tdata);
   assign q_desc.cmd  = cmd_ff;
   assign q_desc.size = BYTE_W'(size_ff);

   always_comb begin
      phase_in = phase_ff;
      size_in  = size_ff;
      fill_in  = fill_ff;
      cmd_in   = cmd_ff;
      xor_in   = xor_ff;
      bank_in  = bank_ff ^ q_push;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = (req_tdata == SYNC_DOLLAR) ? PH_DOLLAR : PH_IDLE;
            end
            PH_DOLLAR: begin
               phase_in = (req_tdata == SYNC_M) ? PH_M : PH_IDLE;
            end
            PH_M: begin
               phase_in = (req_tdata == SYNC_LT) ? PH_ARROW : PH_IDLE;
            end
            PH_ARROW: begin
               if ({1'b0, req_tdata} > 9'(PAYLOAD_DEPTH)) begin
                  phase_in = PH_IDLE;
               end else begin
                  size_in  = SZ_W'(req_tdata);
                  fill_in  = '0;
                  xor_in   = req_tdata;
                  phase_in = PH_SIZE;
               end
            end
            PH_SIZE: begin
               cmd_in   = req_tdata;
               xor_in   = xor_ff ^ req_tdata;
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               if (body_store) begin
                  xor_in  = xor_ff ^ req_tdata;
                  fill_in = fill_ff + 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         size_ff  <= '0;
         fill_ff  <= '0;
         cmd_ff   <= '0;
         xor_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         fill_ff  <= fill_in;
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
         bank_ff  <= bank_in;
      end
   end

   a_stall_only_in_body: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (phase_ff == PH_BODY))
      else $error("front stalled outside payload phase");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (fill_ff <= size_ff))
      else $error("payload fill passed declared size");

   a_push_ends_frame: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (phase_ff == PH_IDLE))
      else $error("frame not closed after descriptor push");

endmodule

@@ rtl/scfr_queue.sv @@
// ----------------------------------------------------------------------------
// scfr_queue
// Two-entry descriptor queue between parser and drain, one entry per bank.
// ----------------------------------------------------------------------------
module scfr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scfr_pkg::desc_type  push_desc,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output scfr_pkg::desc_type  head_desc
);
   import scfr_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff[1];
   assign empty     = (count_ff == 2'd0);
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ pop;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("descriptor pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("descriptor popped from empty queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

@@ rtl/scfr_back.sv @@
// ----------------------------------------------------------------------------
// scfr_back
// Frame drain: holds the two-bank payload buffer and walks each queued frame,
// one word per cycle when not stalled, via a read stage and output register.
// ----------------------------------------------------------------------------
module scfr_back #(
   parameter int PAYLOAD_DEPTH = scfr_pkg::PAYLOAD_DEPTH_DEF,
   parameter int SZ_W          = $clog2(PAYLOAD_DEPTH + 1),
   parameter int AW            = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scfr_pkg::mem_wr_type mem_wr,
   input  logic [AW:0]          mem_wr_addr,
   input  logic                 q_empty,
   input  scfr_pkg::desc_type   q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic [0:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import scfr_pkg::*;

   localparam int MEM_DEPTH = 2 ** (AW + 1);

   logic [BYTE_W-1:0] mem_ff [MEM_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [SZ_W-1:0]   idx_ff, idx_in;
   logic              bank_ff;

   logic              s1_valid_ff, s1_has_ff, s1_last_ff;
   logic [BYTE_W-1:0] s1_cmd_ff;
   logic [6:0]        s1_len_ff;
   logic [5:0]        s1_idx_ff;

   logic              out_valid_ff, out_has_ff, out_last_ff;
   logic [BYTE_W-1:0] out_cmd_ff, out_data_ff;
   logic [6:0]        out_len_ff;
   logic [5:0]        out_idx_ff;

   logic              advance, issue, has, last;
   logic [AW:0]       rd_addr;

   assign advance = !out_valid_ff || rsp_tready;
   assign issue   = advance && !q_empty;
   assign has     = (q_head.size != '0);
   assign last    = !has || ((BYTE_W'(idx_ff) + 8'd1) == q_head.size);
   assign q_pop   = issue && last;
   assign rd_addr = {bank_ff, idx_ff[AW-1:0]};
   assign idx_in  = q_pop ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem_ff[mem_wr_addr] <= mem_wr.data;
      end
      if (issue) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_cmd_ff  <= q_head.cmd;
         s1_len_ff  <= 7'(q_head.size);
         s1_has_ff  <= has;
         s1_idx_ff  <= 6'(idx_ff);
         s1_last_ff <= last;
      end
      if (advance) begin
         out_cmd_ff  <= s1_cmd_ff;
         out_len_ff  <= s1_len_ff;
         out_has_ff  <= s1_has_ff;
         out_idx_ff  <= s1_has_ff ? s1_idx_ff : 6'd0;
         out_data_ff <= s1_has_ff ? rd_data_ff : 8'd0;
         out_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         bank_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            idx_ff <= idx_in;
         end
         bank_ff <= bank_ff ^ q_pop;
         if (advance) begin
            s1_valid_ff  <= issue;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff, out_idx_ff, out_len_ff, out_cmd_ff};
   assign rsp_tuser  = out_has_ff;
   assign rsp_tlast  = out_last_ff;

   a_empty_frame_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_has_ff) |-> (out_last_ff && (out_idx_ff == 6'd0) &&
                                      (out_data_ff == 8'd0)))
      else $error("empty-frame word malformed");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      (issue && has) |-> (BYTE_W'(idx_ff) < q_head.size))
      else $error("drain index beyond frame size");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(idx_ff))
      else $error("read stage moved under output stall");

endmodule

@@ rtl/serial_command_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_unit
// Deframer for '$' 'M' '<' size command payload checksum frames (XOR sum).
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless the input stalls. Payload bytes
// go into one of two buffer banks; a frame whose checksum matches is queued
// and drained as one result word per payload byte (or a single no-data word
// for an empty frame), one word per cycle while rsp_tready is high. The
// input stalls only on payload and checksum bytes while both banks hold
// frames still waiting to drain, so the buffer's single write and read ports
// set these rates. Bad checksums, oversized frames and stray bytes produce no
// output. The buffer needs no clearing after reset.
module serial_command_frame_receiver_unit #(
   parameter int PAYLOAD_DEPTH = scfr_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] command_code, [14:8] frame_length,
                                    // [20:15] byte_index, [28:21] payload_byte
   output logic [0:0]  rsp_tuser,   // [0] has_data
   output logic        rsp_tlast
);
   import scfr_pkg::*;

   localparam int SZ_W = $clog2(PAYLOAD_DEPTH + 1);
   localparam int AW   = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   logic       q_full, q_empty, q_push, q_pop;
   desc_type   q_desc, q_head;
   mem_wr_type mem_wr;
   logic [AW:0] mem_wr_addr;

   scfr_front #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .SZ_W          (SZ_W),
      .AW            (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (q_desc),
      .mem_wr      (mem_wr),
      .mem_wr_addr (mem_wr_addr)
   );

   scfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head_desc (q_head)
   );

   scfr_back #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .SZ_W          (SZ_W),
      .AW            (AW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mem_wr      (mem_wr),
      .mem_wr_addr (mem_wr_addr),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ tb/sv/serial_command_frame_receiver_unit_tb.sv @@
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_unit_tb
// Self-checking bench for the '$' 'M' '<' frame deframer with XOR checksum.
// ----------------------------------------------------------------------------
// Bytes go in one word at a time on the req stream. A behavioral deframer
// runs on every accepted byte and queues the result words that a matching
// checksum releases. The rsp stream is compared word by word against that
// queue. Directed tests cover empty, short and full frames, bad checksums,
// broken headers and oversized frames. Random traffic then mixes
// well-formed frames with noise, with random idle bursts on both sides.
module serial_command_frame_receiver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scfr_pkg::*;

   localparam int DEPTH     = PAYLOAD_DEPTH_DEF;
   localparam int FILL_RAND = 0;
   localparam int FILL_ALT  = 1;
   localparam int MAX_SHOWN = 20;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_DOLLAR,
      PARSE_M,
      PARSE_ARROW,
      PARSE_SIZE,
      PARSE_BODY
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] cmd;
      logic [6:0] len;
      logic       has_data;
      logic [5:0] idx;
      logic [7:0] data;
      logic       last;
   } frame_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [7:0] command_code, [14:8] frame_length,
                             // [20:15] byte_index, [28:21] payload_byte
   logic [0:0]  rsp_tuser;   // [0] has_data
   logic        rsp_tlast;

   parse_phase_type phase;
   logic [6:0]   size_reg;
   logic [7:0]   cmd_reg;
   logic [6:0]   fill;
   logic [7:0]   xsum;
   logic [7:0]   payload_mem [DEPTH];

   frame_word_type pending_words [$];
   int          err_count;
   int          bytes_sent;
   int          frames_sent;
   int          frames_released;
   int          words_checked;
   bit          src_idle_on;
   bit          sink_stall_on;

   serial_command_frame_receiver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input int expd, input int got);
      if (err_count < MAX_SHOWN)
         $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, expd, got);
      err_count++;
   endtask

   // deframer state advance for one accepted byte
   function automatic void track_rx_byte(input logic [7:0] b);
      frame_word_type w;
      case (phase)
         PARSE_IDLE:   phase = (b == SYNC_DOLLAR) ? PARSE_DOLLAR : PARSE_IDLE;
         PARSE_DOLLAR: phase = (b == SYNC_M) ? PARSE_M : PARSE_IDLE;
         PARSE_M:      phase = (b == SYNC_LT) ? PARSE_ARROW : PARSE_IDLE;
         PARSE_ARROW: begin
            if (int'(b) > DEPTH) begin
               phase = PARSE_IDLE;
            end else begin
               size_reg = b[6:0];
               fill     = '0;
               xsum     = b;
               phase    = PARSE_SIZE;
            end
         end
         PARSE_SIZE: begin
            cmd_reg = b;
            xsum   ^= b;
            phase   = PARSE_BODY;
         end
         PARSE_BODY: begin
            if (fill < size_reg) begin
               xsum ^= b;
               payload_mem[fill[5:0]] = b;
               fill++;
            end else begin
               if (xsum == b) begin
                  frames_released++;
                  w.cmd = cmd_reg;
                  w.len = size_reg;
                  if (size_reg == 0) begin
                     w.has_data = 1'b0;
                     w.idx      = '0;
                     w.data     = '0;
                     w.last     = 1'b1;
                     pending_words.insert(pending_words.size(), w);
                  end else begin
                     for (int i = 0; i < int'(size_reg); i++) begin
                        w.has_data = 1'b1;
                        w.idx      = i[5:0];
                        w.data     = payload_mem[i];
                        w.last     = (i + 1 == int'(size_reg));
                        pending_words.insert(pending_words.size(), w);
                     end
                  end
               end
               phase = PARSE_IDLE;
            end
         end
         default: phase = PARSE_IDLE;
      endcase
   endfunction

   task automatic check_word();
      frame_word_type e;
      frame_word_type g;
      g.cmd      = rsp_tdata[7:0];
      g.len      = rsp_tdata[14:8];
      g.idx      = rsp_tdata[20:15];
      g.data     = rsp_tdata[28:21];
      g.has_data = rsp_tuser[0];
      g.last     = rsp_tlast;
      words_checked++;
      if (pending_words.size() == 0) begin
         report_mismatch("unexpected word, cmd", -1, g.cmd);
      end else begin
         e = pending_words.pop_front();
         if (g.cmd != e.cmd) report_mismatch("command_code", e.cmd, g.cmd);
         if (g.len != e.len) report_mismatch("frame_length", e.len, g.len);
         if (g.has_data != e.has_data) report_mismatch("has_data", e.has_data, g.has_data);
         if (g.idx != e.idx) report_mismatch("byte_index", e.idx, g.idx);
         if (g.data != e.data) report_mismatch("payload_byte", e.data, g.data);
         if (g.last != e.last) report_mismatch("last", e.last, g.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word();
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (sink_stall_on && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      @(negedge clock);
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_header();
      send_byte(SYNC_DOLLAR);
      send_byte(SYNC_M);
      send_byte(SYNC_LT);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input int size, input bit bad_sum,
                             input int pattern);
      logic [7:0] sum;
      logic [7:0] b;
      frames_sent++;
      send_header();
      sum = size[7:0];
      send_byte(size[7:0]);
      sum ^= cmd;
      send_byte(cmd);
      for (int i = 0; i < size; i++) begin
         if (pattern == FILL_ALT) b = i[0] ? 8'h00 : 8'hFF;
         else b = 8'($urandom_range(0, 255));
         sum ^= b;
         send_byte(b);
      end
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
   endtask

   task automatic send_oversize(input int size);
      send_header();
      send_byte(size[7:0]);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_broken_header();
      case ($urandom_range(0, 2))
         0: begin
            send_byte(SYNC_DOLLAR);
            send_byte(8'($urandom_range(0, 255)));
         end
         1: begin
            send_byte(SYNC_DOLLAR);
            send_byte(SYNC_M);
            send_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            send_byte(SYNC_DOLLAR);
            send_byte(SYNC_DOLLAR);
            send_byte(SYNC_M);
            send_byte(SYNC_LT);
            send_byte(8'd1);
         end
      endcase
   endtask

   task automatic test_empty_frames();
      send_frame(8'h00, 0, 1'b0, FILL_RAND);
      send_frame(8'hFF, 0, 1'b0, FILL_RAND);
   endtask

   task automatic test_short_frames();
      send_frame(8'hA5, 1, 1'b0, FILL_ALT);
      send_frame(8'h5A, 2, 1'b0, FILL_ALT);
   endtask

   task automatic test_bad_checksum();
      send_frame(8'h11, 3, 1'b1, FILL_RAND);
      send_frame(8'h22, 0, 1'b1, FILL_RAND);
      send_frame(8'h33, 1, 1'b0, FILL_RAND);
   endtask

   task automatic test_broken_header();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_DOLLAR);
      send_byte(SYNC_DOLLAR);
      send_byte(SYNC_M);
      send_byte(SYNC_LT);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(SYNC_DOLLAR);
      send_byte(SYNC_M);
      send_byte(SYNC_DOLLAR);
      send_byte(SYNC_M);
      send_frame(8'h44, 1, 1'b0, FILL_RAND);
   endtask

   task automatic test_oversize();
      send_oversize(DEPTH + 1);
      send_oversize(255);
      send_frame(8'h55, 0, 1'b0, FILL_RAND);
   endtask

   task automatic test_full_frame();
      send_frame(8'h80, DEPTH, 1'b0, FILL_ALT);
      send_frame(8'h7F, DEPTH, 1'b0, FILL_RAND);
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int stop_at;
      int pick;
      int size;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            src_idle_on   = $urandom_range(0, 1);
            sink_stall_on = $urandom_range(0, 1);
         end
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            size = $urandom_range(0, 99);
            if (size < 88) size = $urandom_range(0, 8);
            else if (size < 97) size = $urandom_range(9, DEPTH - 1);
            else size = DEPTH;
            send_frame(8'($urandom_range(0, 255)), size, 1'b0, FILL_RAND);
         end else if (pick < 82) begin
            send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b1, FILL_RAND);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            send_broken_header();
         end else begin
            send_oversize($urandom_range(DEPTH + 1, 255));
         end
      end
   endtask

   task automatic test_back_to_back();
      src_idle_on   = 1'b0;
      sink_stall_on = 1'b0;
      repeat (8) send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b0, FILL_RAND);
      send_frame(8'hC3, 4, 1'b1, FILL_RAND);
      send_frame(8'h3C, DEPTH, 1'b0, FILL_RAND);
   endtask

   initial begin
      int waited;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      err_count     = 0;
      bytes_sent    = 0;
      frames_sent   = 0;
      frames_released = 0;
      words_checked = 0;
      src_idle_on   = 1'b1;
      sink_stall_on = 1'b1;
      phase         = PARSE_IDLE;
      size_reg      = '0;
      cmd_reg       = '0;
      fill          = '0;
      xsum          = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_frames();
      test_short_frames();
      test_bad_checksum();
      test_broken_header();
      test_oversize();
      test_full_frame();
      test_random_traffic(75);
      test_back_to_back();

      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_words.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words.size() != 0)
         report_mismatch("words never delivered", 0, pending_words.size());
      repeat (16) @(posedge clock);

      $display("sent %0d bytes in %0d framed sequences plus noise", bytes_sent, frames_sent);
      $display("%0d frames released, %0d result words checked", frames_released,
               words_checked);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
